FILE: sv/wte_pkg.sv
// Shared types, constants and the character class function for the word token extractor.
// Depends on nothing; every other file of the block imports it.
package wte_pkg;

   // Fixed field widths of the streaming ports.
   localparam int BYTE_BITS   = 8;
   localparam int WORD_BITS   = 64;
   localparam int LENGTH_BITS = 4;
   localparam int COUNT_BITS  = 2;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 4;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_DUP_MODE = 2'd0,
      CSR_MIN_LEN  = 2'd1,
      CSR_MAX_LEN  = 2'd2
   } csr_index_type;

   // Reset values of the configuration registers.
   localparam logic       DUP_MODE_RESET = 1'b0;
   localparam logic [3:0] MIN_LEN_RESET  = 4'd1;
   localparam logic [2:0] MAX_LEN_RESET  = 3'd6;

   // Input kinds.
   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_EOF  = 1'b1;

   // Character bounds of the word class.
   localparam logic [BYTE_BITS-1:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [BYTE_BITS-1:0] CHAR_HYPHEN     = 8'h2D;
   localparam logic [BYTE_BITS-1:0] CHAR_LOWER_A    = 8'h61;
   localparam logic [BYTE_BITS-1:0] CHAR_LOWER_Z    = 8'h7A;
   localparam logic [BYTE_BITS-1:0] CHAR_UPPER_A    = 8'h41;
   localparam logic [BYTE_BITS-1:0] CHAR_UPPER_Z    = 8'h5A;
   localparam logic [BYTE_BITS-1:0] CHAR_DIGIT_0    = 8'h30;
   localparam logic [BYTE_BITS-1:0] CHAR_DIGIT_9    = 8'h39;

   // Configuration as seen by the datapath.
   typedef struct packed {
      logic       dup_mode;
      logic [3:0] min_len;
      logic [2:0] max_len;
   } cfg_type;

   // One input item held in the input register.
   typedef struct packed {
      logic                 kind;
      logic [BYTE_BITS-1:0] byte_value;
   } item_type;

   // What one item produces: how many words (zero to two) and their contents.
   typedef struct packed {
      logic [COUNT_BITS-1:0]  count;
      logic [LENGTH_BITS-1:0] length;
      logic [WORD_BITS-1:0]   word;
   } result_type;

   // True for letters, digits, underscore and hyphen.
   function automatic logic is_word_char(input logic [BYTE_BITS-1:0] b);
      logic lower;
      logic upper;
      logic digit;
      lower = (b >= CHAR_LOWER_A) && (b <= CHAR_LOWER_Z);
      upper = (b >= CHAR_UPPER_A) && (b <= CHAR_UPPER_Z);
      digit = (b >= CHAR_DIGIT_0) && (b <= CHAR_DIGIT_9);
      return lower || upper || digit || (b == CHAR_UNDERSCORE) || (b == CHAR_HYPHEN);
   endfunction

endpackage

FILE: sv/word_token_extractor_core.sv
// Top level of the word token extractor: configuration registers and the pipeline wiring.
// Depends on wte_pkg, wte_req_reg, wte_tokenizer and wte_rsp_reg.
//
//   Port group  Direction  Payload                               Accepted when
//   req_*       in         tdata byte_value, tuser kind          req_tvalid && req_tready
//   rsp_*       out        tdata word, word_length; tlast last   rsp_tvalid && rsp_tready
//   csr_*       in         csr_index register, csr_data value    csr_valid && csr_ready
//
// One item per cycle while each item makes at most one word and rsp_tready is high; an
// item making two words (duplicate mode on overflow) holds the result register until both
// copies leave, so its repeat count sets the rate. A word is offered once its item has
// left the input register. Reset clears the stored length, both valid flags and the
// configuration; the character store is not cleared. A stall on rsp_tready backs up
// through the input register to req_tready; the configuration port is always ready.
module word_token_extractor_core #(
   parameter int MAX_CHARS = 8
) (
   input  logic        clock,
   input  logic        reset,
   // Input byte stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // byte_value[7:0]
   input  logic        req_tuser,   // kind[0]
   // Word stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // word[63:0], word_length[67:64], zero[71:68]
   output logic        rsp_tlast,   // last[0]
   // Configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [wte_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [wte_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import wte_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   item_type   item;
   result_type result;
   logic       item_valid;
   logic       advance;
   logic       rsp_free;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DUP_MODE: cfg_in.dup_mode = csr_data[0];
            CSR_MIN_LEN:  cfg_in.min_len  = csr_data[3:0];
            CSR_MAX_LEN:  cfg_in.max_len  = csr_data[2:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dup_mode <= DUP_MODE_RESET;
         cfg_ff.min_len  <= MIN_LEN_RESET;
         cfg_ff.max_len  <= MAX_LEN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The held item moves on when it makes no word or the result register has room.
   assign advance = item_valid && ((result.count == '0) || rsp_free);

   wte_req_reg u_req_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   wte_tokenizer #(
      .MAX_CHARS (MAX_CHARS)
   ) u_tokenizer (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .item    (item),
      .advance (advance),
      .result  (result)
   );

   wte_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && (result.count != '0)),
      .result     (result),
      .free       (rsp_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: sv/wte_req_reg.sv
// Input register of the word token extractor: one item slot in front of the datapath.
// Depends on wte_pkg.
module wte_req_reg (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [wte_pkg::BYTE_BITS-1:0] req_tdata,   // byte_value[7:0]
   input  logic                          req_tuser,   // kind[0]
   input  logic                          advance,
   output logic                          item_valid,
   output wte_pkg::item_type             item
);
   import wte_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   logic     accept;

   // The slot takes a new item when it is empty or drains in this cycle.
   assign req_tready = !valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.kind       <= req_tuser;
         item_ff.byte_value <= req_tdata;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

FILE: sv/wte_tokenizer.sv
// Character store, length register and the single-pass token logic of the word token extractor.
// Depends on wte_pkg.
module wte_tokenizer #(
   parameter int MAX_CHARS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  wte_pkg::cfg_type    cfg,
   input  wte_pkg::item_type   item,
   input  logic                advance,
   output wte_pkg::result_type result
);
   import wte_pkg::*;

   localparam int LEN_W = $clog2(MAX_CHARS + 1);
   localparam int IDX_W = $clog2(MAX_CHARS);
   localparam logic [LENGTH_BITS-1:0] TOP_LIMIT = LENGTH_BITS'(MAX_CHARS - 1);

   logic [BYTE_BITS-1:0]   store_ff [MAX_CHARS];
   logic [BYTE_BITS-1:0]   store_in [MAX_CHARS];
   logic [LEN_W-1:0]       cur_len_ff;
   logic [LEN_W-1:0]       cur_len_in;

   logic [BYTE_BITS-1:0]   app_store [MAX_CHARS];
   logic [BYTE_BITS-1:0]   src_store [MAX_CHARS];
   logic [LEN_W-1:0]       app_len;
   logic [LEN_W-1:0]       emit_len;
   logic [LENGTH_BITS-1:0] limit_wide;
   logic [LEN_W-1:0]       limit;
   logic                   word_byte;
   logic                   overflow;
   logic                   long_enough;
   logic [LENGTH_BITS-1:0] emit_len_wide;
   logic [WORD_BITS-1:0]   word_packed;
   logic [COUNT_BITS-1:0]  word_count;

   // The length limit saturates so the store never overflows.
   always_comb begin
      if ({1'b0, cfg.max_len} < TOP_LIMIT) begin
         limit_wide = {1'b0, cfg.max_len};
      end else begin
         limit_wide = TOP_LIMIT;
      end
      limit = limit_wide[LEN_W-1:0];
   end

   assign word_byte = (item.kind == KIND_DATA) && is_word_char(item.byte_value);
   assign app_len   = cur_len_ff + LEN_W'(1);
   assign overflow  = app_len > limit;

   // Store with the incoming byte placed after the current characters.
   always_comb begin
      for (int i = 0; i < MAX_CHARS; i++) begin
         if (IDX_W'(i) == cur_len_ff[IDX_W-1:0]) begin
            app_store[i] = item.byte_value;
         end else begin
            app_store[i] = store_ff[i];
         end
      end
   end

   // Pick the emitted characters, the next store and the next length.
   always_comb begin
      if (word_byte) begin
         emit_len  = app_len;
         src_store = app_store;
         store_in  = app_store;
         if (overflow && cfg.dup_mode) begin
            // Sliding window: drop the first character.
            for (int i = 0; i < MAX_CHARS - 1; i++) begin
               store_in[i] = app_store[i + 1];
            end
            cur_len_in = cur_len_ff;
         end else if (overflow) begin
            cur_len_in = '0;
         end else begin
            cur_len_in = app_len;
         end
      end else begin
         // Delimiter or end of file flushes the pending word.
         emit_len   = cur_len_ff;
         src_store  = store_ff;
         store_in   = store_ff;
         cur_len_in = '0;
      end
   end

   assign emit_len_wide = LENGTH_BITS'(emit_len);
   assign long_enough   = (emit_len != '0) && (emit_len_wide >= cfg.min_len);

   // Number of words caused by this item.
   always_comb begin
      if (word_byte) begin
         word_count = {1'b0, cfg.dup_mode && long_enough} + {1'b0, overflow && long_enough};
      end else begin
         word_count = {1'b0, long_enough};
      end
   end

   // Pack the valid characters, first one lowest, unused bytes zero.
   always_comb begin
      word_packed = '0;
      for (int i = 0; i < MAX_CHARS; i++) begin
         if (LEN_W'(i) < emit_len) begin
            word_packed[i*BYTE_BITS +: BYTE_BITS] = src_store[i];
         end
      end
   end

   assign result.count  = word_count;
   assign result.length = emit_len_wide;
   assign result.word   = word_packed;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_len_ff <= '0;
      end else if (advance) begin
         cur_len_ff <= cur_len_in;
      end
   end

   // Character store is undefined until written and has no reset.
   always_ff @(posedge clock) begin
      if (advance) begin
         store_ff <= store_in;
      end
   end

   // The stored length always leaves room for one more character.
   a_len_in_range: assert property (@(posedge clock) disable iff (reset)
      cur_len_ff < LEN_W'(MAX_CHARS))
      else $error("stored length reached the store depth");

   // Two words for one item only come from duplicate mode on overflow.
   a_two_words_dup: assert property (@(posedge clock) disable iff (reset)
      (result.count == 2'd2) |-> (cfg.dup_mode && word_byte && overflow))
      else $error("two words outside duplicate-mode overflow");

endmodule

FILE: sv/wte_rsp_reg.sv
// Result register of the word token extractor: holds one word and how often it still goes out.
// Depends on wte_pkg.
module wte_rsp_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  wte_pkg::result_type    result,
   output logic                   free,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [71:0]            rsp_tdata,   // word[63:0], word_length[67:64], zero[71:68]
   output logic                   rsp_tlast    // last[0]
);
   import wte_pkg::*;

   logic [COUNT_BITS-1:0]  cnt_ff;
   logic [COUNT_BITS-1:0]  cnt_in;
   logic [WORD_BITS-1:0]   word_ff;
   logic [LENGTH_BITS-1:0] length_ff;
   logic                   take;

   assign rsp_tvalid = cnt_ff != '0;
   assign take       = rsp_tvalid && rsp_tready;
   // Empty next cycle: nothing held, or the final copy leaves now.
   assign free       = (cnt_ff == '0) || ((cnt_ff == 2'd1) && rsp_tready);

   always_comb begin
      cnt_in = cnt_ff;
      if (load) begin
         cnt_in = result.count;
      end else if (take) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff   <= result.word;
         length_ff <= result.length;
      end
   end

   assign rsp_tdata = {4'b0000, length_ff, word_ff};
   assign rsp_tlast = cnt_ff == 2'd1;

   // The repeat count never goes past two copies.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("result repeat count out of range");

   // A new word is only loaded when the held one is gone or leaving.
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load |-> free)
      else $error("result register overwritten while busy");

   // A word is never shown with zero length.
   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (length_ff != '0))
      else $error("word shown with zero length");

endmodule
